// ===== src/sdf_pkg.sv =====
`default_nettype none

package sdf_pkg;

    // storage sizing
    localparam int MAX_ELEMENTS   = 1024;
    localparam int MAX_SEPARATORS = 4;
    localparam int SEP_REGS       = 4;
    localparam int SEP_LIMIT      = (MAX_SEPARATORS < SEP_REGS) ? MAX_SEPARATORS : SEP_REGS;

    localparam int ADDR_W  = $clog2(MAX_ELEMENTS);
    localparam int TOTAL_W = $clog2(MAX_ELEMENTS + 1);
    localparam int WORD_W  = 32;
    localparam int SEPN_W  = 3;
    localparam int COUNT_W = 11;
    localparam int CFG_IDX_W = 3;

    localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_FULL = TOTAL_W'(MAX_ELEMENTS);
    localparam logic [SEPN_W-1:0]  SEP_LIMIT_N = SEPN_W'(SEP_LIMIT);

    // request commands
    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_QUERY  = 2'd2
    } sdf_cmd_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEP_COUNT   = 3'd0,
        CFG_SEP_VALUE_0 = 3'd1,
        CFG_SEP_VALUE_1 = 3'd2,
        CFG_SEP_VALUE_2 = 3'd3,
        CFG_SEP_VALUE_3 = 3'd4
    } sdf_cfg_idx_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } sdf_state_t;

    // separator setup handed to the engine
    typedef struct packed {
        logic [SEPN_W-1:0]                count;
        logic [SEP_REGS-1:0][WORD_W-1:0]  value;
    } sdf_sep_cfg_t;

    // finished query result toward the output register
    typedef struct packed {
        logic               valid;
        logic [COUNT_W-1:0] count;
    } sdf_res_t;

    // saturating increment of a segment count
    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] h);
        sat_inc = (h == COUNT_MAX) ? h : h + COUNT_W'(1);
    endfunction

endpackage

`default_nettype wire

// ===== src/sdf_if.sv =====
`default_nettype none

// request channel: command and value
interface sdf_req_if
    import sdf_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic [WORD_W-1:0]  value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

// response channel: segment count of a query
interface sdf_rsp_if
    import sdf_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] segment_count;

    modport source (output valid, output segment_count, input ready);
    modport sink   (input valid, input segment_count, output ready);
endinterface

`default_nettype wire

// ===== src/segment_document_frequency_core.sv =====
// segment document frequency core
//
// requests arrive on req (command, value); query results leave on rsp
// (segment_count). separator setup is written through cfg_we / cfg_index /
// cfg_data; the user must do so only while the block is idle, which the
// block itself does not enforce. clear and append leave req.ready high, so
// they can follow back to back.
// a query walks the stored elements one per cycle through a single shared
// compare unit fed by the element memory read port: when the walk ends,
// the engine loads the result into the output register once that register
// is free, and req.ready returns in the same cycle.
// the output register holds a result while rsp.ready is low; clears and
// appends are still taken then, but a following query holds its result
// inside the engine and keeps req.ready low until the register frees up.
// reset empties the sequence and clears the separator registers; memory
// contents are not cleared, the element count bounds every read, so no
// clearing pass is needed.

`default_nettype none

module segment_document_frequency_core
    import sdf_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [WORD_W-1:0]     cfg_data,
    sdf_req_if.sink                    req,
    sdf_rsp_if.source                  rsp
);

    logic [SEPN_W-1:0]                sep_count_reg;
    logic [SEP_REGS-1:0][WORD_W-1:0]  sep_value_reg;
    logic                             out_valid_reg;
    logic [COUNT_W-1:0]               out_count_reg;

    sdf_sep_cfg_t sep;
    sdf_res_t     res;
    logic         res_ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_count_reg <= '0;
            sep_value_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SEP_COUNT:   sep_count_reg    <= cfg_data[SEPN_W-1:0];
                CFG_SEP_VALUE_0: sep_value_reg[0] <= cfg_data;
                CFG_SEP_VALUE_1: sep_value_reg[1] <= cfg_data;
                CFG_SEP_VALUE_2: sep_value_reg[2] <= cfg_data;
                CFG_SEP_VALUE_3: sep_value_reg[3] <= cfg_data;
                default:         sep_count_reg    <= sep_count_reg;
            endcase
        end
    end

    assign sep = '{count: sep_count_reg, value: sep_value_reg};

    sdf_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (req.valid),
        .cmd_ready (req.ready),
        .command   (req.command),
        .value     (req.value),
        .sep       (sep),
        .res       (res),
        .res_ready (res_ready)
    );

    // output register
    assign res_ready = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_ready)
            out_valid_reg <= res.valid;
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res.valid)
            out_count_reg <= res.count;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.segment_count = out_count_reg;

endmodule

`default_nettype wire

// ===== src/sdf_engine.sv =====
`default_nettype none

module sdf_engine
    import sdf_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    output logic                    cmd_ready,
    input  wire logic [1:0]         command,
    input  wire logic [WORD_W-1:0]  value,
    input  wire sdf_sep_cfg_t       sep,
    output sdf_res_t                res,
    input  wire logic               res_ready
);

    logic [WORD_W-1:0] mem [MAX_ELEMENTS];

    sdf_state_t         state_reg, state_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [TOTAL_W-1:0] idx_reg, idx_next;
    logic               pend_reg, pend_next;
    logic               found_reg, found_next;
    logic [COUNT_W-1:0] hits_reg, hits_next;
    logic [WORD_W-1:0]  qval_reg, qval_next;
    logic [WORD_W-1:0]  rd_data_reg;

    logic               accept;
    logic               wr_en;
    logic               rd_en;
    logic               scan_more;
    logic               scan_done;
    logic [SEPN_W-1:0]  sep_n;
    logic [SEP_REGS-1:0] sep_hit;
    logic               is_sep;

    assign accept    = cmd_valid && cmd_ready;
    assign scan_more = idx_reg < total_reg;
    assign scan_done = !scan_more && !pend_reg;

    // separators in use, limited to the register count
    assign sep_n = (sep.count > SEP_LIMIT_N) ? SEP_LIMIT_N : sep.count;

    // shared compare unit on the element just read
    always_comb
    begin
        for (int k = 0; k < SEP_REGS; k++)
        begin
            sep_hit[k] = (SEPN_W'(k) < sep_n) && (sep.value[k] == rd_data_reg);
        end
    end
    assign is_sep = |sep_hit;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && command == CMD_QUERY)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_done)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (res_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        cmd_ready = 1'b0;
        rd_en     = 1'b0;
        res.valid = 1'b0;
        res.count = hits_reg;
        unique case (state_reg)
            ST_IDLE:   cmd_ready = 1'b1;
            ST_SCAN:   rd_en     = scan_more;
            ST_FINISH: res.valid = 1'b1;
            default:   cmd_ready = 1'b0;
        endcase
    end

    assign wr_en = accept && (command == CMD_APPEND) && (total_reg < TOTAL_FULL);

    // datapath next values
    always_comb
    begin
        total_next = total_reg;
        idx_next   = idx_reg;
        pend_next  = 1'b0;
        found_next = found_reg;
        hits_next  = hits_reg;
        qval_next  = qval_reg;
        if (accept)
        begin
            unique case (command)
                CMD_CLEAR:  total_next = '0;
                CMD_APPEND:
                begin
                    if (wr_en)
                        total_next = total_reg + TOTAL_W'(1);
                end
                CMD_QUERY:
                begin
                    qval_next  = value;
                    idx_next   = '0;
                    found_next = 1'b0;
                    hits_next  = '0;
                end
                default: total_next = total_reg;
            endcase
        end
        else if (state_reg == ST_SCAN)
        begin
            if (scan_more)
            begin
                idx_next  = idx_reg + TOTAL_W'(1);
                pend_next = 1'b1;
            end
            // one element per cycle through the compare unit
            if (pend_reg)
            begin
                if (is_sep)
                begin
                    if (found_reg)
                        hits_next = sat_inc(hits_reg);
                    found_next = 1'b0;
                end
                else if (rd_data_reg == qval_reg)
                begin
                    found_next = 1'b1;
                end
            end
            else if (scan_done && found_reg)
            begin
                // close the last segment
                hits_next  = sat_inc(hits_reg);
                found_next = 1'b0;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            total_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            pend_reg  <= pend_next;
        end
    end

    // walk registers
    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        found_reg <= found_next;
        hits_reg  <= hits_next;
        qval_reg  <= qval_next;
    end

    // element memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[total_reg[ADDR_W-1:0]] <= value;
        if (rd_en)
            rd_data_reg <= mem[idx_reg[ADDR_W-1:0]];
    end

endmodule

`default_nettype wire

// ===== verif/tb_segment_document_frequency_core.sv =====
`timescale 1ns / 100ps

module tb_segment_document_frequency_core
    import sdf_pkg::*;
();

    // codes that the package leaves out
    localparam logic [1:0]           CMD_UNUSED      = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 3'd7;

    localparam int NUM_STEPS     = 33;
    localparam int FILL_ITEMS    = 200;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 35;
    localparam int PALETTE_SIZE  = 6;
    localparam int SEQ_CAP       = 48;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 4000000;
    localparam int PRINT_LIMIT   = 50;

    typedef enum bit {STEP_REQUEST, STEP_CONFIG} step_kind_t;

    typedef struct {
        step_kind_t           kind;
        logic [1:0]           cmd;
        logic [CFG_IDX_W-1:0] idx;
        logic [WORD_W-1:0]    data;
        bit                   typed;
        logic [COUNT_W-1:0]   count;
    } step_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0]    cfg_data;

    sdf_req_if req_ch ();
    sdf_rsp_if rsp_ch ();

    segment_document_frequency_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // predictor state: separator setup and stored elements
    logic [SEPN_W-1:0]  split_count_reg;
    logic [WORD_W-1:0]  split_words [SEP_REGS];
    logic [WORD_W-1:0]  stored_words [MAX_ELEMENTS];
    int                 stored_total;
    logic [COUNT_W-1:0] pending_counts [$];
    logic [COUNT_W-1:0] oldest_count;
    int                 error_count;
    int                 cycle_count;
    step_t              directed_steps [NUM_STEPS];

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit is_split_word(input logic [WORD_W-1:0] w);
        int in_use;
        in_use = (int'(split_count_reg) > SEP_LIMIT) ? SEP_LIMIT : int'(split_count_reg);
        for (int k = 0; k < in_use; k++)
        begin
            if (split_words[k] == w)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // number of segments holding v at least once
    function automatic logic [COUNT_W-1:0] predict_segment_count(input logic [WORD_W-1:0] v);
        int hits;
        bit seen;
        hits = 0;
        seen = 1'b0;
        for (int i = 0; i < stored_total; i++)
        begin
            if (is_split_word(stored_words[i]))
            begin
                if (seen)
                    hits++;
                seen = 1'b0;
            end
            else if (stored_words[i] == v)
                seen = 1'b1;
        end
        if (seen)
            hits++;
        if (hits > int'(COUNT_MAX))
            hits = int'(COUNT_MAX);
        return COUNT_W'(hits);
    endfunction

    // update the stored sequence; returns 1 when a count is due
    function automatic bit apply_request(input logic [1:0] cmd, input logic [WORD_W-1:0] v,
                                         output logic [COUNT_W-1:0] cnt);
        cnt = '0;
        case (cmd)
            CMD_CLEAR:
                stored_total = 0;
            CMD_APPEND:
            begin
                if (stored_total < MAX_ELEMENTS)
                begin
                    stored_words[stored_total] = v;
                    stored_total++;
                end
            end
            CMD_QUERY:
            begin
                cnt = predict_segment_count(v);
                return 1'b1;
            end
            default:
                ;
        endcase
        return 1'b0;
    endfunction

    function automatic void apply_config(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [WORD_W-1:0] data);
        if (idx == CFG_SEP_COUNT)
            split_count_reg = data[SEPN_W-1:0];
        else if (idx >= CFG_SEP_VALUE_0 && idx <= CFG_SEP_VALUE_3)
            split_words[2'(idx - CFG_SEP_VALUE_0)] = data;
    endfunction

    function automatic step_t req_step(input logic [1:0] cmd, input logic [WORD_W-1:0] v,
                                       input bit typed = 1'b0,
                                       input logic [COUNT_W-1:0] cnt = '0);
        step_t s;
        s.kind  = STEP_REQUEST;
        s.cmd   = cmd;
        s.idx   = CFG_SEP_COUNT;
        s.data  = v;
        s.typed = typed;
        s.count = cnt;
        return s;
    endfunction

    function automatic step_t cfg_step(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [WORD_W-1:0] data);
        step_t s;
        s.kind  = STEP_CONFIG;
        s.cmd   = CMD_CLEAR;
        s.idx   = idx;
        s.data  = data;
        s.typed = 1'b0;
        s.count = '0;
        return s;
    endfunction

    // sender gap: mostly short, a few long
    function automatic int pick_gap(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 45)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    // one request; the expectation is queued at the accepting edge
    task automatic send_request(input logic [1:0] cmd, input logic [WORD_W-1:0] v,
                                input bit typed, input logic [COUNT_W-1:0] typed_count,
                                input int gap);
        logic [COUNT_W-1:0] predicted;
        req_ch.valid   <= 1'b1;
        req_ch.command <= cmd;
        req_ch.value   <= v;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        if (apply_request(cmd, v, predicted))
            pending_counts = {pending_counts, (typed ? typed_count : predicted)};
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_until_idle(input int settle);
        req_ch.valid <= 1'b0;
        while (pending_counts.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // write enable is left high so that writes can follow back to back
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [WORD_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        apply_config(idx, data);
    endtask

    task automatic load_separators(input logic [WORD_W-1:0] count_word,
                                   input logic [WORD_W-1:0] words [SEP_REGS]);
        wait_until_idle(SETTLE_CYCLES);
        write_register(CFG_SEP_COUNT, count_word);
        for (int k = 0; k < SEP_REGS; k++)
            write_register(CFG_IDX_W'(CFG_SEP_VALUE_0 + k), words[k]);
        write_register(CFG_IDX_W'($urandom_range(CFG_UNMAPPED_LO, CFG_UNMAPPED_HI)), $urandom());
        cfg_we <= 1'b0;
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_counts.size() == 0)
                report_mismatch($sformatf("segment_count %0d with no query waiting",
                                          rsp_ch.segment_count));
            else
            begin
                oldest_count = pending_counts.pop_front();
                if (rsp_ch.segment_count !== oldest_count)
                    report_mismatch($sformatf("segment_count %0d, predicted %0d",
                                              rsp_ch.segment_count, oldest_count));
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side: ready bursts and stalls of random length
    initial
    begin
        int hold;
        int r;
        bit accept;
        hold   = 0;
        accept = 1'b0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold == 0)
            begin
                accept = !accept;
                r = $urandom_range(0, 99);
                if (accept)
                    hold = (r < 15) ? $urandom_range(60, 200) : $urandom_range(1, 12);
                else
                    hold = (r < 85) ? $urandom_range(1, 3) : $urandom_range(15, 60);
            end
            hold--;
            rsp_ch.ready <= accept;
        end
    end

    // stimulus
    initial
    begin
        int                r;
        int                count_sel;
        bit                steady;
        logic [1:0]        cmd;
        logic [WORD_W-1:0] v;
        logic [WORD_W-1:0] count_word;
        logic [WORD_W-1:0] palette [PALETTE_SIZE];
        logic [WORD_W-1:0] seps [SEP_REGS];
        logic [WORD_W-1:0] fill_pool [5];

        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_SEP_COUNT;
        cfg_data       = '0;
        req_ch.valid   = 1'b0;
        req_ch.command = CMD_CLEAR;
        req_ch.value   = '0;
        error_count    = 0;
        cycle_count    = 0;
        stored_total   = 0;
        split_count_reg = '0;
        foreach (split_words[k])
            split_words[k] = '0;

        directed_steps = '{
            req_step(CMD_QUERY,  32'h0000_0000, 1'b1, 11'd0),  // empty after reset
            req_step(CMD_UNUSED, 32'h5A5A_5A5A),
            req_step(CMD_APPEND, 32'h7FFF_FFFF),
            req_step(CMD_APPEND, 32'h8000_0000),
            req_step(CMD_APPEND, 32'h0000_0000),
            req_step(CMD_QUERY,  32'h0000_0000, 1'b1, 11'd1),  // no separators: one segment
            req_step(CMD_QUERY,  32'h8000_0000, 1'b1, 11'd1),
            req_step(CMD_QUERY,  32'h0001_2345, 1'b1, 11'd0),  // absent value
            cfg_step(CFG_SEP_COUNT,   32'd1),
            cfg_step(CFG_SEP_VALUE_0, 32'h0000_0000),
            cfg_step(CFG_UNMAPPED_LO, 32'hFFFF_FFFF),
            req_step(CMD_QUERY,  32'h0000_0000, 1'b1, 11'd0),  // separator holds no segment
            req_step(CMD_QUERY,  32'h7FFF_FFFF, 1'b1, 11'd1),
            req_step(CMD_APPEND, 32'h0000_0000),                // empty segment
            req_step(CMD_APPEND, 32'h7FFF_FFFF),
            req_step(CMD_QUERY,  32'h7FFF_FFFF),
            cfg_step(CFG_SEP_COUNT,   32'd7),                   // above the register count
            cfg_step(CFG_SEP_VALUE_1, 32'h8000_0000),
            cfg_step(CFG_SEP_VALUE_2, 32'h8000_0000),           // duplicate separator
            cfg_step(CFG_SEP_VALUE_3, 32'hFFFF_FFFF),
            req_step(CMD_QUERY,  32'h8000_0000, 1'b1, 11'd0),
            req_step(CMD_QUERY,  32'h7FFF_FFFF),
            req_step(CMD_APPEND, 32'hFFFF_FFFF),
            req_step(CMD_APPEND, 32'h8000_0000),
            req_step(CMD_QUERY,  32'hFFFF_FFFF, 1'b1, 11'd0),
            req_step(CMD_CLEAR,  32'hFFFF_FFFF),
            req_step(CMD_QUERY,  32'h7FFF_FFFF, 1'b1, 11'd0),  // cleared
            req_step(CMD_APPEND, 32'h7FFF_FFFF),
            req_step(CMD_QUERY,  32'h7FFF_FFFF, 1'b1, 11'd1),
            cfg_step(CFG_SEP_COUNT,   32'hFFFF_FFF8),           // only the low bits count
            req_step(CMD_APPEND, 32'h0000_0000),
            req_step(CMD_QUERY,  32'h0000_0000, 1'b1, 11'd1),
            req_step(CMD_CLEAR,  32'h0000_0000)
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed steps
        for (int i = 0; i < NUM_STEPS; i++)
        begin
            if (directed_steps[i].kind == STEP_CONFIG)
            begin
                if (i == 0 || directed_steps[i-1].kind != STEP_CONFIG)
                    wait_until_idle(SETTLE_CYCLES);
                write_register(directed_steps[i].idx, directed_steps[i].data);
                if (i == NUM_STEPS - 1 || directed_steps[i+1].kind != STEP_CONFIG)
                    cfg_we <= 1'b0;
            end
            else
                send_request(directed_steps[i].cmd, directed_steps[i].data,
                             directed_steps[i].typed, directed_steps[i].count,
                             pick_gap(1'b0));
        end

        // long sequence back to back, then long scans
        seps[0] = 32'h0000_0000;
        seps[1] = 32'h8000_0000;
        seps[2] = $urandom();
        seps[3] = $urandom();
        load_separators(32'd2, seps);
        fill_pool = '{32'h0000_0000, 32'h8000_0000, 32'd5, 32'd6, 32'h7FFF_FFFF};
        for (int i = 0; i < FILL_ITEMS; i++)
            send_request(CMD_APPEND, fill_pool[$urandom_range(0, 4)], 1'b0, '0, 0);
        for (int i = 0; i < 5; i++)
            send_request(CMD_QUERY, fill_pool[i], 1'b0, '0, pick_gap(1'b0));
        send_request(CMD_CLEAR, $urandom(), 1'b0, '0, pick_gap(1'b0));

        // random phases: short sequences over a small set of words
        for (int p = 0; p < PHASES; p++)
        begin
            for (int k = 0; k < PALETTE_SIZE; k++)
            begin
                case ($urandom_range(0, 7))
                    0:       palette[k] = 32'h7FFF_FFFF;
                    1:       palette[k] = 32'h8000_0000;
                    2:       palette[k] = 32'h0000_0000;
                    3:       palette[k] = 32'hFFFF_FFFF;
                    default: palette[k] = $urandom();
                endcase
            end
            for (int k = 0; k < SEP_REGS; k++)
                seps[k] = ($urandom_range(0, 9) < 7) ?
                          palette[$urandom_range(0, PALETTE_SIZE - 1)] : $urandom();
            r = $urandom_range(0, 99);
            count_sel = (r < 15) ? 0 : (r < 25) ? $urandom_range(5, 7) : $urandom_range(1, 4);
            count_word = {($urandom_range(0, 1) ? 29'($urandom()) : 29'd0), 3'(count_sel)};
            load_separators(count_word, seps);
            steady = ($urandom_range(0, 3) == 0);

            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                // hold off until every count is back
                if (k == PHASE_ITEMS / 2 && (p == 0 || $urandom_range(0, 2) == 0))
                    wait_until_idle(1);
                r = $urandom_range(0, 99);
                v = $urandom();
                if (stored_total >= SEQ_CAP || r < 4)
                    cmd = CMD_CLEAR;
                else if (r < 8)
                    cmd = CMD_UNUSED;
                else if (r < 62)
                begin
                    cmd = CMD_APPEND;
                    if ($urandom_range(0, 99) < 85)
                        v = palette[$urandom_range(0, PALETTE_SIZE - 1)];
                end
                else
                begin
                    cmd = CMD_QUERY;
                    r = $urandom_range(0, 99);
                    if (r < 70)
                        v = palette[$urandom_range(0, PALETTE_SIZE - 1)];
                    else if (r < 85)
                        v = split_words[$urandom_range(0, SEP_REGS - 1)];
                end
                send_request(cmd, v, 1'b0, '0, pick_gap(steady));
            end
        end

        // drain and verdict
        wait_until_idle(MAX_ELEMENTS + 8);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
